// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the histogram RTL.
// CHK_IMPLY checks a same-cycle implication, CHK_NEXT checks the following cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gcsh_pkg.sv =====
package gcsh_pkg;

	// Grid shape and counter size
	localparam int GRID_COLUMNS = 16;
	localparam int GRID_ROWS    = 16;
	localparam int COUNT_BITS   = 32;
	localparam int CELL_TOTAL   = GRID_COLUMNS * GRID_ROWS;

	// Counter store
	localparam int STORE_DEPTH = 256;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

	// Field widths fixed by the interface
	localparam int OUT_BITS = 32;
	localparam int ADD_BITS = 32;
	localparam int DIV_BITS = 16;
	localparam int STEP_BITS = $clog2(DIV_BITS);

	// Operation codes
	localparam logic [1:0] OP_BIN   = 2'd0;
	localparam logic [1:0] OP_MERGE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Health status codes
	localparam logic [1:0] ST_NON_INFECTED = 2'd0;
	localparam logic [1:0] ST_INFECTED     = 2'd1;
	localparam logic [1:0] ST_IMMUNE       = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
	localparam logic [1:0] REG_AREA_LENGTH = 2'd1;
	localparam logic [1:0] REG_CELL_WIDTH  = 2'd2;
	localparam logic [1:0] REG_CELL_LENGTH = 2'd3;

	// One cell record: three status counters
	typedef struct packed {
		logic [COUNT_BITS-1:0] healthy;
		logic [COUNT_BITS-1:0] infected;
		logic [COUNT_BITS-1:0] immune;
	} cell_counts_t;

	// Divider request and result
	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quotient;
		logic [DIV_BITS-1:0] remainder;
	} div_res_t;

	// Store ports
	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
	} store_rd_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
		cell_counts_t         data;
	} store_wr_t;

endpackage

// ===== rtl/core/gcsh_div.sv =====
`include "assert_macros.svh"

module gcsh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  gcsh_pkg::div_req_t req,
	output gcsh_pkg::div_res_t res
);

	logic                               busy_q;
	logic                               done_q;
	logic [gcsh_pkg::STEP_BITS-1:0]     step_q;
	logic [gcsh_pkg::DIV_BITS-1:0]      rem_q;
	logic [gcsh_pkg::DIV_BITS-1:0]      quo_q;
	logic [gcsh_pkg::DIV_BITS-1:0]      dvs_q;
	logic [gcsh_pkg::DIV_BITS:0]        shifted;
	logic                               ge;
	logic [gcsh_pkg::DIV_BITS:0]        diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[gcsh_pkg::DIV_BITS-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	// Load on start, then advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == gcsh_pkg::STEP_BITS'(gcsh_pkg::DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient share the shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[gcsh_pkg::DIV_BITS-1:0] : shifted[gcsh_pkg::DIV_BITS-1:0];
			quo_q <= {quo_q[gcsh_pkg::DIV_BITS-2:0], ge};
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

	`CHK_IMPLY(a_no_restart, clk, arst_n, req.start, !busy_q, "divider restarted while busy")
	`CHK_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q && !busy_q, "done held or busy after done")

endmodule

// ===== rtl/core/gcsh_store.sv =====
`include "assert_macros.svh"

module gcsh_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gcsh_pkg::store_rd_t    rd,
	input  gcsh_pkg::store_wr_t    wr,
	output gcsh_pkg::cell_counts_t rd_data
);

	gcsh_pkg::cell_counts_t              mem [gcsh_pkg::STORE_DEPTH];
	logic [gcsh_pkg::STORE_DEPTH-1:0]    valid_q;
	gcsh_pkg::cell_counts_t              rd_data_q;
	logic                                rd_valid_q;

	// Track written entries; reset clears them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_valid_q <= valid_q[rd.addr];
			end
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	// Unwritten entries read as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

	`CHK_IMPLY(a_port_excl, clk, arst_n, rd.en, !wr.en, "store read and write in one cycle")

endmodule

// ===== rtl/core/grid_cell_status_histogram.sv =====
// The shared divider retires one quotient bit per cycle: bin runs it twice (column, row);
//   merge and read split the cell index with a shift and mask; misses end early.
// Throughput: one word at a time; input stalls from acceptance until the result is queued.
// Reset: arst_n clears state, output valid, config to 64/64/4/4 and all cell counters.
`include "assert_macros.svh"

module grid_cell_status_histogram (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration
	input  logic                cfg_write_en,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// Input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic [1:0]          health_status,
	input  logic [7:0]          cell_index,
	input  logic [31:0]         add_non_infected,
	input  logic [31:0]         add_infected,
	input  logic [31:0]         add_immune,
	// Output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [3:0]          cell_column,
	output logic [3:0]          cell_row,
	output logic [31:0]         count_non_infected,
	output logic [31:0]         count_infected,
	output logic [31:0]         count_immune,
	output logic                saturated
);

	localparam int SUM_W = ((gcsh_pkg::COUNT_BITS > gcsh_pkg::ADD_BITS) ?
		gcsh_pkg::COUNT_BITS : gcsh_pkg::ADD_BITS) + 1;
	localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({gcsh_pkg::COUNT_BITS{1'b1}});

	typedef enum logic [3:0] {
		S_IDLE, S_LOCX, S_DIVX, S_LOCY, S_DIVY, S_IDX, S_READ, S_MOD, S_OUT
	} state_t;

	typedef struct packed {
		logic [gcsh_pkg::COUNT_BITS-1:0] value;
		logic                            sat;
	} sat_sum_t;

	// Saturating add; a stored counter never exceeds the maximum
	function automatic sat_sum_t sat_add(input logic [gcsh_pkg::COUNT_BITS-1:0] a,
			input logic [gcsh_pkg::ADD_BITS-1:0] b);
		logic [SUM_W-1:0] sum;
		sat_sum_t         r;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum > COUNT_MAX) begin
			r.value = COUNT_MAX[gcsh_pkg::COUNT_BITS-1:0];
			r.sat   = 1'b1;
		end else begin
			r.value = sum[gcsh_pkg::COUNT_BITS-1:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

	// Low output bits of a counter
	function automatic logic [gcsh_pkg::OUT_BITS-1:0] to_out(
			input logic [gcsh_pkg::COUNT_BITS-1:0] c);
		logic [SUM_W-1:0] e;
		e = SUM_W'(c);
		return e[gcsh_pkg::OUT_BITS-1:0];
	endfunction

	state_t                          state_q;

	// Configuration registers
	logic [15:0]                     area_width_q;
	logic [15:0]                     area_length_q;
	logic [15:0]                     cell_width_q;
	logic [15:0]                     cell_length_q;

	// Captured input word
	logic [1:0]                      op_q;
	logic signed [15:0]              pos_x_q;
	logic signed [15:0]              pos_y_q;
	logic [1:0]                      status_q;
	logic [7:0]                      cell_index_q;
	logic [gcsh_pkg::ADD_BITS-1:0]   add_non_q;
	logic [gcsh_pkg::ADD_BITS-1:0]   add_inf_q;
	logic [gcsh_pkg::ADD_BITS-1:0]   add_imm_q;

	// Located cell and pending result
	logic [7:0]                      col_q;
	logic [7:0]                      row_q;
	logic [gcsh_pkg::ADDR_BITS-1:0]  addr_q;
	logic                            res_hit_q;
	logic [31:0]                     res_non_q;
	logic [31:0]                     res_inf_q;
	logic [31:0]                     res_imm_q;
	logic                            res_sat_q;

	// Output register
	logic                            out_valid_q;
	logic                            hit_q;
	logic [3:0]                      col_out_q;
	logic [3:0]                      row_out_q;
	logic [31:0]                     non_out_q;
	logic [31:0]                     inf_out_q;
	logic [31:0]                     imm_out_q;
	logic                            sat_out_q;

	gcsh_pkg::div_req_t              div_req;
	gcsh_pkg::div_res_t              div_res;
	gcsh_pkg::store_rd_t             st_rd;
	gcsh_pkg::store_wr_t             st_wr;
	gcsh_pkg::cell_counts_t          st_data;

	logic                            accept;
	logic                            axis_y;
	logic signed [15:0]              axis_pos;
	logic [15:0]                     axis_ext;
	logic [15:0]                     axis_size;
	logic [15:0]                     axis_cells;
	logic [17:0]                     t_ext;
	logic [15:0]                     t_pos;
	logic [15:0]                     span;
	logic [15:0]                     prod;
	logic                            axis_miss;
	logic [15:0]                     cell_k;
	logic                            out_free;
	logic                            out_load;
	logic                            out_fields_zero;
	logic [gcsh_pkg::ADD_BITS-1:0]   inc_non;
	logic [gcsh_pkg::ADD_BITS-1:0]   inc_inf;
	logic [gcsh_pkg::ADD_BITS-1:0]   inc_imm;
	sat_sum_t                        new_non;
	sat_sum_t                        new_inf;
	sat_sum_t                        new_imm;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_OUT) && out_free;

	// Select the axis being located and offset the position into the area
	always_comb begin
		axis_y     = (state_q == S_LOCY) || (state_q == S_DIVY);
		axis_pos   = axis_y ? pos_y_q : pos_x_q;
		axis_ext   = axis_y ? area_length_q : area_width_q;
		axis_size  = axis_y ? cell_length_q : cell_width_q;
		axis_cells = axis_y ? 16'(gcsh_pkg::GRID_ROWS) : 16'(gcsh_pkg::GRID_COLUMNS);
		t_ext      = {{2{axis_pos[15]}}, axis_pos} + {3'b000, axis_ext[15:1]};
		t_pos      = t_ext[15:0];
		span       = {axis_ext[15:1], 1'b0};
		prod       = t_pos - div_res.remainder;
		axis_miss  = (prod >= span) || (div_res.quotient >= axis_cells);
		cell_k     = 16'(div_res.quotient[7:0]) * 16'(gcsh_pkg::GRID_COLUMNS) + 16'(col_q);
	end

	// Drive the shared divider
	always_comb begin
		div_req = '0;
		unique case (state_q) inside
			S_LOCX, S_LOCY: begin
				div_req.start    = (axis_size != '0) && !t_ext[17];
				div_req.dividend = t_pos;
				div_req.divisor  = axis_size;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// Per-status increments: one for bin, received counts for merge, none for read
	always_comb begin
		inc_non = '0;
		inc_inf = '0;
		inc_imm = '0;
		if (op_q == gcsh_pkg::OP_BIN) begin
			inc_non = gcsh_pkg::ADD_BITS'(status_q == gcsh_pkg::ST_NON_INFECTED);
			inc_inf = gcsh_pkg::ADD_BITS'(status_q == gcsh_pkg::ST_INFECTED);
			inc_imm = gcsh_pkg::ADD_BITS'(status_q == gcsh_pkg::ST_IMMUNE);
		end else if (op_q == gcsh_pkg::OP_MERGE) begin
			inc_non = add_non_q;
			inc_inf = add_inf_q;
			inc_imm = add_imm_q;
		end
		new_non = sat_add(st_data.healthy, inc_non);
		new_inf = sat_add(st_data.infected, inc_inf);
		new_imm = sat_add(st_data.immune, inc_imm);
	end

	// Store access: read the cell, write it back in the next cycle (bin and merge only)
	always_comb begin
		st_rd.en   = (state_q == S_READ);
		st_rd.addr = addr_q;
		st_wr.en   = (state_q == S_MOD) &&
			((op_q == gcsh_pkg::OP_BIN) || (op_q == gcsh_pkg::OP_MERGE));
		st_wr.addr = addr_q;
		st_wr.data.healthy  = new_non.value;
		st_wr.data.infected = new_inf.value;
		st_wr.data.immune   = new_imm.value;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q  <= 16'd64;
			area_length_q <= 16'd64;
			cell_width_q  <= 16'd4;
			cell_length_q <= 16'd4;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				gcsh_pkg::REG_AREA_WIDTH:  area_width_q  <= cfg_data;
				gcsh_pkg::REG_AREA_LENGTH: area_length_q <= cfg_data;
				gcsh_pkg::REG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				gcsh_pkg::REG_CELL_LENGTH: cell_length_q <= cfg_data;
			endcase
		end
	end

	// Sequencer, captured word and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			op_q         <= gcsh_pkg::OP_BIN;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			status_q     <= '0;
			cell_index_q <= '0;
			add_non_q    <= '0;
			add_inf_q    <= '0;
			add_imm_q    <= '0;
			col_q        <= '0;
			row_q        <= '0;
			addr_q       <= '0;
			res_hit_q    <= 1'b0;
			res_non_q    <= '0;
			res_inf_q    <= '0;
			res_imm_q    <= '0;
			res_sat_q    <= 1'b0;
			hit_q        <= 1'b0;
			col_out_q    <= '0;
			row_out_q    <= '0;
			non_out_q    <= '0;
			inf_out_q    <= '0;
			imm_out_q    <= '0;
			sat_out_q    <= 1'b0;
		end else begin
			// Raise the output word on a load, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= operation;
						pos_x_q      <= pos_x;
						pos_y_q      <= pos_y;
						status_q     <= health_status;
						cell_index_q <= cell_index;
						add_non_q    <= add_non_infected;
						add_inf_q    <= add_infected;
						add_imm_q    <= add_immune;
						res_hit_q    <= 1'b0;
						res_non_q    <= '0;
						res_inf_q    <= '0;
						res_imm_q    <= '0;
						res_sat_q    <= 1'b0;
						col_q        <= '0;
						row_q        <= '0;
						unique case (operation) inside
							gcsh_pkg::OP_BIN: state_q <= S_LOCX;
							gcsh_pkg::OP_MERGE, gcsh_pkg::OP_READ: begin
								if (17'(cell_index) < 17'(gcsh_pkg::CELL_TOTAL)) begin
									state_q <= S_IDX;
								end else begin
									state_q <= S_OUT;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_LOCX: state_q <= div_req.start ? S_DIVX : S_OUT;
				S_DIVX: begin
					if (div_res.done) begin
						col_q   <= div_res.quotient[7:0];
						state_q <= axis_miss ? S_OUT : S_LOCY;
					end
				end
				S_LOCY: state_q <= div_req.start ? S_DIVY : S_OUT;
				S_DIVY: begin
					if (div_res.done) begin
						row_q  <= div_res.quotient[7:0];
						addr_q <= cell_k[gcsh_pkg::ADDR_BITS-1:0];
						if (axis_miss || (17'(cell_k) >= 17'(gcsh_pkg::STORE_DEPTH))) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				// Split the row-major index: grid columns are a power of two
				S_IDX: begin
					col_q   <= 8'(cell_index_q % gcsh_pkg::GRID_COLUMNS);
					row_q   <= 8'(cell_index_q / gcsh_pkg::GRID_COLUMNS);
					addr_q  <= cell_index_q[gcsh_pkg::ADDR_BITS-1:0];
					state_q <= S_READ;
				end
				S_READ: state_q <= S_MOD;
				S_MOD: begin
					res_hit_q <= 1'b1;
					res_non_q <= to_out(new_non.value);
					res_inf_q <= to_out(new_inf.value);
					res_imm_q <= to_out(new_imm.value);
					res_sat_q <= new_non.sat || new_inf.sat || new_imm.sat;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					// Hold the result until the output register is free
					if (out_load) begin
						hit_q       <= res_hit_q;
						col_out_q   <= res_hit_q ? col_q[3:0] : 4'd0;
						row_out_q   <= res_hit_q ? row_q[3:0] : 4'd0;
						non_out_q   <= res_non_q;
						inf_out_q   <= res_inf_q;
						imm_out_q   <= res_imm_q;
						sat_out_q   <= res_sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	gcsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	gcsh_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (st_rd),
		.wr      (st_wr),
		.rd_data (st_data)
	);

	assign out_valid          = out_valid_q;
	assign hit                = hit_q;
	assign cell_column        = col_out_q;
	assign cell_row           = row_out_q;
	assign count_non_infected = non_out_q;
	assign count_infected     = inf_out_q;
	assign count_immune       = imm_out_q;
	assign saturated          = sat_out_q;

	// Every field but valid is zero on a miss
	assign out_fields_zero = (count_non_infected == '0) && (count_infected == '0) &&
		(count_immune == '0) && !saturated && (cell_column == '0) && (cell_row == '0);

	`CHK_IMPLY(a_miss_zero, clk, arst_n, out_valid && !hit, out_fields_zero, "miss not zero")
	`CHK_IMPLY(a_sat_hit, clk, arst_n, out_valid && saturated, hit, "saturation flagged on a miss")
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall, "input not stalled after accept")

endmodule

// ===== tb/sv/gcsh_count_tracker.sv =====
module gcsh_count_tracker
	import gcsh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [1:0]         health_status,
	input  logic [7:0]         cell_index,
	input  logic [31:0]        add_non_infected,
	input  logic [31:0]        add_infected,
	input  logic [31:0]        add_immune,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	input  logic [3:0]         cell_column,
	input  logic [3:0]         cell_row,
	input  logic [31:0]        count_non_infected,
	input  logic [31:0]        count_infected,
	input  logic [31:0]        count_immune,
	input  logic               saturated,
	output int unsigned        mismatches,
	output int unsigned        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        hit;
		logic [3:0]  column;
		logic [3:0]  row;
		logic [31:0] healthy;
		logic [31:0] infected;
		logic [31:0] immune;
		logic        saturated;
	} cell_report_t;

	// Shadow copy of the area setup and of the counter store
	logic [15:0] area_w, area_l, cell_w, cell_l;
	logic [COUNT_BITS-1:0] healthy_tally [STORE_DEPTH];
	logic [COUNT_BITS-1:0] infected_tally [STORE_DEPTH];
	logic [COUNT_BITS-1:0] immune_tally [STORE_DEPTH];

	cell_report_t expected_reports [$];
	int unsigned fail_count;

	// Map one coordinate to its cell slot along an axis; 0 on a miss
	function automatic bit find_axis(input logic signed [15:0] p, input logic [15:0] extent,
			input logic [15:0] size, input int cells, output int slot);
		int half, t, c, sz, ext;
		sz = size;
		ext = extent;
		half = ext / 2;
		t = int'(p) + half;
		if (sz == 0 || t < 0)
			return 1'b0;
		c = t / sz;
		// the last cell may reach past the edge, but must start inside it
		if (longint'(c) * sz >= 2 * half || c >= cells)
			return 1'b0;
		slot = c;
		return 1'b1;
	endfunction

	// Add with clipping at the counter maximum
	function automatic logic [COUNT_BITS-1:0] add_clip(input logic [COUNT_BITS-1:0] a,
			input logic [COUNT_BITS-1:0] b, inout bit clipped);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[COUNT_BITS]) begin
			clipped = 1'b1;
			return '1;
		end
		return s[COUNT_BITS-1:0];
	endfunction

	// Apply one word to the shadow store and build the report it should give
	function automatic cell_report_t apply_word(input logic [1:0] op,
			input logic signed [15:0] x, input logic signed [15:0] y, input logic [1:0] st,
			input logic [7:0] idx, input logic [31:0] add_ni, input logic [31:0] add_inf,
			input logic [31:0] add_imm);
		cell_report_t r;
		int col, row, entry;
		bit ok, clipped;
		r = '0;
		col = 0;
		row = 0;
		entry = 0;
		ok = 1'b0;
		clipped = 1'b0;
		if (op == OP_BIN) begin
			if (find_axis(x, area_w, cell_w, GRID_COLUMNS, col) &&
					find_axis(y, area_l, cell_l, GRID_ROWS, row) &&
					row * GRID_COLUMNS + col < STORE_DEPTH) begin
				entry = row * GRID_COLUMNS + col;
				ok = 1'b1;
				case (st)
					ST_NON_INFECTED: healthy_tally[entry] =
						add_clip(healthy_tally[entry], 1, clipped);
					ST_INFECTED: infected_tally[entry] =
						add_clip(infected_tally[entry], 1, clipped);
					ST_IMMUNE: immune_tally[entry] = add_clip(immune_tally[entry], 1, clipped);
					// unknown status: report the cell, count nothing
					default: ;
				endcase
			end
		end else if (op == OP_MERGE || op == OP_READ) begin
			if (idx < CELL_TOTAL) begin
				entry = idx;
				col = idx % GRID_COLUMNS;
				row = idx / GRID_COLUMNS;
				ok = 1'b1;
				if (op == OP_MERGE) begin
					healthy_tally[entry] = add_clip(healthy_tally[entry], add_ni, clipped);
					infected_tally[entry] = add_clip(infected_tally[entry], add_inf, clipped);
					immune_tally[entry] = add_clip(immune_tally[entry], add_imm, clipped);
				end
			end
		end
		if (ok) begin
			r.hit = 1'b1;
			r.column = col[3:0];
			r.row = row[3:0];
			r.healthy = healthy_tally[entry][31:0];
			r.infected = infected_tally[entry][31:0];
			r.immune = immune_tally[entry][31:0];
			r.saturated = clipped;
		end
		return r;
	endfunction

	function automatic string show_report(input cell_report_t r);
		return $sformatf("hit=%0d col=%0d row=%0d ni=%0d inf=%0d imm=%0d sat=%0d",
			r.hit, r.column, r.row, r.healthy, r.infected, r.immune, r.saturated);
	endfunction

	// Track config, predict on every accepted input word, compare every output word
	always @(posedge clk or negedge arst_n) begin
		cell_report_t want, got;
		if (!arst_n) begin
			area_w = 16'd64;
			area_l = 16'd64;
			cell_w = 16'd4;
			cell_l = 16'd4;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				healthy_tally[i] = '0;
				infected_tally[i] = '0;
				immune_tally[i] = '0;
			end
			expected_reports.delete();
			fail_count = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{hit, cell_column, cell_row, count_non_infected, count_infected,
					count_immune, saturated};
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: output word with nothing expected: %s",
							$realtime, show_report(got));
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: cell report mismatch\n  expected %s\n  actual   %s",
								$realtime, show_report(want), show_report(got));
					end
				end
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(apply_word(operation, pos_x, pos_y, health_status,
					cell_index, add_non_infected, add_infected, add_immune));
			if (cfg_write_en) begin
				case (cfg_index)
					REG_AREA_WIDTH: area_w = cfg_data;
					REG_AREA_LENGTH: area_l = cfg_data;
					REG_CELL_WIDTH: cell_w = cfg_data;
					REG_CELL_LENGTH: cell_l = cfg_data;
					default: ;
				endcase
			end
			pending <= expected_reports.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ===== tb/sv/grid_cell_status_histogram_test.sv =====
module grid_cell_status_histogram_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gcsh_pkg::*;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;
	localparam int WORDS_PER_PHASE = 125;
	localparam int PHASES = 7;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [1:0]         cfg_index = REG_AREA_WIDTH;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = OP_BIN;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic [1:0]         health_status = ST_NON_INFECTED;
	logic [7:0]         cell_index = '0;
	logic [31:0]        add_non_infected = '0;
	logic [31:0]        add_infected = '0;
	logic [31:0]        add_immune = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [3:0]         cell_column;
	logic [3:0]         cell_row;
	logic [31:0]        count_non_infected;
	logic [31:0]        count_infected;
	logic [31:0]        count_immune;
	logic               saturated;

	int unsigned mismatches;
	int unsigned pending;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off_armed = 1'b0;
	int hold_off_count = 0;
	int cycle_count = 0;
	logic [15:0] area_w_now, area_l_now, cell_w_now, cell_l_now;

	grid_cell_status_histogram u_dut (.*);

	gcsh_count_tracker u_tracker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: one long hold-off when armed, random stalls otherwise
	always @(posedge clk) begin
		if (hold_off_armed && hold_off_count < HOLD_OFF_CYCLES) begin
			out_stall <= 1'b1;
			hold_off_count <= hold_off_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Write one register and advance; the caller drops the enable
	task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] aw, input logic [15:0] al,
			input logic [15:0] cw, input logic [15:0] cl);
		put_reg(REG_AREA_WIDTH, aw);
		put_reg(REG_AREA_LENGTH, al);
		put_reg(REG_CELL_WIDTH, cw);
		put_reg(REG_CELL_LENGTH, cl);
		cfg_write_en <= 1'b0;
		area_w_now = aw;
		area_l_now = al;
		cell_w_now = cw;
		cell_l_now = cl;
	endtask

	// Offer one input word after a random idle gap, hold it until accepted
	task automatic send_word(input logic [1:0] op, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic [1:0] st, input logic [7:0] idx,
			input logic [31:0] a_ni, input logic [31:0] a_inf, input logic [31:0] a_imm);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pos_x <= x;
		pos_y <= y;
		health_status <= st;
		cell_index <= idx;
		add_non_infected <= a_ni;
		add_infected <= a_inf;
		add_immune <= a_imm;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Position mostly within the area or a margin past its edges, sometimes anywhere
	function automatic logic [15:0] near_position(input logic [15:0] extent,
			input logic [15:0] size);
		int e, s, span, v;
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		e = extent;
		s = size;
		span = e / 2 + 2 * s + 2;
		if (span > 40000)
			span = 40000;
		v = int'($urandom_range(2 * span)) - span;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Merge amounts: small, huge near the limit, or anything
	function automatic logic [31:0] merge_amount();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom_range(15);
			1: v = $urandom;
			2: v = 32'hFFFF_FFFF - $urandom_range(3);
			default: v = $urandom_range(1000);
		endcase
		return v;
	endfunction

	task automatic send_random_word();
		logic [1:0] op, st;
		logic [7:0] idx;
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			op = OP_BIN;
		else if (roll < 75)
			op = OP_MERGE;
		else if (roll < 94)
			op = OP_READ;
		else
			op = OP_UNKNOWN;
		st = 2'($urandom_range(2));
		if ($urandom_range(15) == 0)
			st = ST_UNKNOWN;
		// favor a few cells so merges drive them into saturation
		idx = 8'($urandom);
		if ($urandom_range(1) == 0)
			idx = 8'($urandom_range(3));
		send_word(op, near_position(area_w_now, cell_w_now),
			near_position(area_l_now, cell_l_now), st, idx,
			merge_amount(), merge_amount(), merge_amount());
	endtask

	// Area setup per random phase: width, length, cell width, cell length
	function automatic logic [63:0] phase_setup(input int p);
		case (p)
			0: return {16'd32, 16'd48, 16'd2, 16'd3};
			1: return {16'd65535, 16'd1, 16'd0, 16'd65535};
			2: return {16'd32768, 16'd32768, 16'd2048, 16'd2048};
			3: return {16'd100, 16'd30, 16'd7, 16'd1};
			4: return {16'd2, 16'd2, 16'd1, 16'd1};
			5: return {16'd65535, 16'd65535, 16'd32768, 16'd1};
			default: return {16'd0, 16'd17, 16'd1, 16'd0};
		endcase
	endfunction

	initial begin
		logic [63:0] setup;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words on the default 16 x 16 grid of 4 x 4 cells
		configure(16'd64, 16'd64, 16'd4, 16'd4);
		send_word(OP_BIN, -32, -32, ST_NON_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_BIN, 31, 31, ST_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_BIN, 32, 0, ST_NON_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_BIN, 0, -33, ST_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_BIN, -32768, 32767, ST_IMMUNE, 8'd255, 0, 0, 0);
		send_word(OP_BIN, 32767, -32768, ST_NON_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_BIN, 0, 0, ST_IMMUNE, 8'd0, 0, 0, 0);
		send_word(OP_BIN, -1, -1, ST_UNKNOWN, 8'd0, 0, 0, 0);
		send_word(OP_MERGE, 0, 0, ST_NON_INFECTED, 8'd0, 32'hFFFF_FFFF, 0, 1);
		send_word(OP_MERGE, 0, 0, ST_NON_INFECTED, 8'd255, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
		send_word(OP_BIN, 31, 31, ST_NON_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_READ, 0, 0, ST_NON_INFECTED, 8'd0, 0, 0, 0);
		send_word(OP_READ, 0, 0, ST_NON_INFECTED, 8'd255, 0, 0, 0);
		send_word(OP_READ, 0, 0, ST_NON_INFECTED, 8'd136, 0, 0, 0);
		send_word(OP_MERGE, 0, 0, ST_NON_INFECTED, 8'd128, 0, 0, 0);
		send_word(OP_UNKNOWN, -1, -1, ST_UNKNOWN, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_word(OP_READ, 0, 0, ST_NON_INFECTED, 8'd119, 0, 0, 0);
		send_word(OP_MERGE, 0, 0, ST_NON_INFECTED, 8'd17, 1, 2, 3);
		send_word(OP_BIN, -29, -28, ST_IMMUNE, 8'd0, 0, 0, 0);
		drain();

		// Random phases, each with its own area setup and one of four idling mixes
		for (int p = 0; p < PHASES; p++) begin
			setup = phase_setup(p);
			configure(setup[63:48], setup[47:32], setup[31:16], setup[15:0]);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 88;
					recv_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 88;
				end
				default: begin
					sender_idle_pct = 37;
					recv_stall_pct <= 37;
				end
			endcase
			// hold the output off once so the block backs up into its input
			if (p == 0)
				hold_off_armed <= 1'b1;
			repeat (WORDS_PER_PHASE) send_random_word();
			drain();
		end

		repeat (45) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gcsh_pkg.sv
rtl/core/gcsh_div.sv
rtl/core/gcsh_store.sv
rtl/core/grid_cell_status_histogram.sv
tb/sv/gcsh_count_tracker.sv
tb/sv/grid_cell_status_histogram_test.sv
